// ===== rtl/grb_pkg.sv =====
package grb_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_GLYPH_HEIGHT = 32;
    localparam int DEF_GLYPH_COUNT      = 256;

    // Field widths
    localparam int CODE_W     = 8;
    localparam int LROW_W     = 5;
    localparam int ROWBITS_W  = 8;
    localparam int POS_W      = 16;
    localparam int COLOUR_W   = 32;
    localparam int SPAN_Y_W   = 17;
    localparam int MASK_W     = 8;
    localparam int GHEIGHT_W  = 6;
    localparam int GWIDTH_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Hard ceiling on rows per draw, from the row counter width
    localparam int ROW_LIMIT = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [GHEIGHT_W-1:0] RST_GLYPH_HEIGHT  = 6'd16;
    localparam logic [GWIDTH_W-1:0]  RST_GLYPH_WIDTH   = 4'd8;
    localparam logic [POS_W-1:0]     RST_SCREEN_WIDTH  = 16'd640;
    localparam logic [POS_W-1:0]     RST_SCREEN_HEIGHT = 16'd480;

    // Request kinds carried in tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic load_we;
        logic draw_start;
        logic rd_issue;
    } grb_cmd_t;

    typedef struct packed {
        logic rows_zero;
        logic s1_free;
        logic s1_valid;
        logic row_is_last;
    } grb_status_t;

    // Keep the n leftmost bits of a row byte, n from 0 to 8 and above
    function automatic logic [MASK_W-1:0] left_mask(input logic [GWIDTH_W-1:0] n);
        logic [MASK_W-1:0] m;
        if (n >= GWIDTH_W'(MASK_W)) begin
            m = '1;
        end else begin
            m = ~({MASK_W{1'b1}} >> n[2:0]);
        end
        return m;
    endfunction

endpackage

// ===== rtl/grb_ram.sv =====
module grb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/grb_ctrl.sv =====
module grb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  func,
    output logic                  s_tready,
    input  grb_pkg::grb_status_t  status,
    output grb_pkg::grb_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd.load_we    = 1'b0;
        cmd.draw_start = 1'b0;
        cmd.rd_issue   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (func == grb_pkg::FUNC_LOAD) begin
                        cmd.load_we = 1'b1;
                    end else begin
                        cmd.draw_start = 1'b1;
                        // zero-height draw gives nothing, stay put
                        if (!status.rows_zero) begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                cmd.rd_issue = status.s1_free;
                if (status.s1_free && status.row_is_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait until the last row has left the read stage
                if (!status.s1_valid) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/grb_datapath.sv =====
module grb_datapath #(
    parameter int MAX_GLYPH_HEIGHT = grb_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int GLYPH_COUNT      = grb_pkg::DEF_GLYPH_COUNT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [grb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [grb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request fields
    input  logic [grb_pkg::CODE_W-1:0]       code,
    input  logic [grb_pkg::LROW_W-1:0]       load_row,
    input  logic [grb_pkg::ROWBITS_W-1:0]    row_bits,
    input  logic [grb_pkg::POS_W-1:0]        pos_x,
    input  logic [grb_pkg::POS_W-1:0]        pos_y,
    input  logic [grb_pkg::COLOUR_W-1:0]     colour,
    // controller link
    input  grb_pkg::grb_cmd_t                cmd,
    output grb_pkg::grb_status_t             status,
    // result
    output logic                             m_valid,
    input  logic                             m_tready,
    output logic [grb_pkg::POS_W-1:0]        span_x,
    output logic [grb_pkg::SPAN_Y_W-1:0]     span_y,
    output logic [grb_pkg::MASK_W-1:0]       pixel_mask,
    output logic [grb_pkg::COLOUR_W-1:0]     pixel_colour,
    output logic                             last_row
);

    localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(GLYPH_COUNT);
    localparam int NCODES = 2 ** grb_pkg::CODE_W;
    localparam int LIMIT  = (MAX_GLYPH_HEIGHT < grb_pkg::ROW_LIMIT) ?
                            MAX_GLYPH_HEIGHT : grb_pkg::ROW_LIMIT;
    localparam int RCW    = $clog2(grb_pkg::ROW_LIMIT);

    // configuration registers
    logic [grb_pkg::GHEIGHT_W-1:0] gheight_reg;
    logic [grb_pkg::GWIDTH_W-1:0]  gwidth_reg;
    logic [grb_pkg::POS_W-1:0]     swidth_reg;
    logic [grb_pkg::POS_W-1:0]     sheight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gheight_reg <= grb_pkg::RST_GLYPH_HEIGHT;
            gwidth_reg  <= grb_pkg::RST_GLYPH_WIDTH;
            swidth_reg  <= grb_pkg::RST_SCREEN_WIDTH;
            sheight_reg <= grb_pkg::RST_SCREEN_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                grb_pkg::CFG_GLYPH_HEIGHT:
                    gheight_reg <= cfg_data[grb_pkg::GHEIGHT_W-1:0];
                grb_pkg::CFG_GLYPH_WIDTH:
                    gwidth_reg <= cfg_data[grb_pkg::GWIDTH_W-1:0];
                grb_pkg::CFG_SCREEN_WIDTH:
                    swidth_reg <= cfg_data;
                grb_pkg::CFG_SCREEN_HEIGHT:
                    sheight_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // code wrap table, worked out at elaboration
    logic [CW-1:0] code_mod_tbl [NCODES];
    for (genvar i = 0; i < NCODES; i++) begin : g_mod
        assign code_mod_tbl[i] = CW'(i % GLYPH_COUNT);
    end

    logic [AW-1:0] base_now;
    logic          lrow_ok;
    assign base_now = AW'(code_mod_tbl[code]) * AW'(MAX_GLYPH_HEIGHT);
    assign lrow_ok  = (32'(load_row) < MAX_GLYPH_HEIGHT);

    // per-draw setup
    logic [grb_pkg::GHEIGHT_W-1:0] rows_now;
    logic [grb_pkg::GWIDTH_W-1:0]  cols_now;
    logic [grb_pkg::POS_W-1:0]     room_x;
    logic [grb_pkg::GWIDTH_W-1:0]  room_sat;
    logic [grb_pkg::MASK_W-1:0]    xmask_now;

    always_comb begin
        rows_now = (gheight_reg > grb_pkg::GHEIGHT_W'(LIMIT)) ?
                   grb_pkg::GHEIGHT_W'(LIMIT) : gheight_reg;
        cols_now = (gwidth_reg > grb_pkg::GWIDTH_W'(grb_pkg::MASK_W)) ?
                   grb_pkg::GWIDTH_W'(grb_pkg::MASK_W) : gwidth_reg;
        room_x   = swidth_reg - pos_x;
        room_sat = (room_x >= grb_pkg::POS_W'(grb_pkg::MASK_W)) ?
                   grb_pkg::GWIDTH_W'(grb_pkg::MASK_W) : room_x[grb_pkg::GWIDTH_W-1:0];
        if (pos_x >= swidth_reg) begin
            xmask_now = '0;
        end else begin
            xmask_now = grb_pkg::left_mask(cols_now) & grb_pkg::left_mask(room_sat);
        end
    end

    logic [AW-1:0]                 base_reg;
    logic [grb_pkg::GHEIGHT_W-1:0] rows_reg;
    logic [grb_pkg::MASK_W-1:0]    xmask_reg;
    logic [grb_pkg::POS_W-1:0]     px_reg;
    logic [grb_pkg::POS_W-1:0]     py_reg;
    logic [grb_pkg::COLOUR_W-1:0]  colour_reg;

    always_ff @(posedge aclk) begin
        if (cmd.draw_start) begin
            base_reg   <= base_now;
            rows_reg   <= rows_now;
            xmask_reg  <= xmask_now;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            colour_reg <= colour;
        end
    end

    // row counter and read stage
    logic [RCW-1:0] row_reg, row_next;
    logic [RCW-1:0] s1_row_reg, s1_row_next;
    logic           s1_last_reg, s1_last_next;
    logic           s1_v_reg, s1_v_next;
    logic           advance;
    logic           row_last;

    assign advance  = !m_valid || m_tready;
    assign row_last = (grb_pkg::GHEIGHT_W'(row_reg) + 1'b1) == rows_reg;

    always_comb begin
        row_next     = row_reg;
        s1_row_next  = s1_row_reg;
        s1_last_next = s1_last_reg;
        s1_v_next    = s1_v_reg;
        if (cmd.draw_start) begin
            row_next = '0;
        end else if (cmd.rd_issue) begin
            row_next     = row_reg + 1'b1;
            s1_row_next  = row_reg;
            s1_last_next = row_last;
        end
        if (!s1_v_reg || advance) begin
            s1_v_next = cmd.rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
        end else begin
            row_reg  <= row_next;
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_row_reg  <= s1_row_next;
        s1_last_reg <= s1_last_next;
    end

    // glyph store
    logic [AW-1:0]                 ram_addr;
    logic [grb_pkg::ROWBITS_W-1:0] ram_rdata;

    assign ram_addr = cmd.load_we ? (base_now + AW'(load_row)) : (base_reg + AW'(row_reg));

    grb_ram #(
        .WIDTH (grb_pkg::ROWBITS_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.load_we && lrow_ok),
        .re    (cmd.rd_issue),
        .addr  (ram_addr),
        .wdata (row_bits),
        .rdata (ram_rdata)
    );

    // output register
    logic [grb_pkg::SPAN_Y_W-1:0] y_now;
    logic                         m_valid_reg, m_valid_next;
    logic [grb_pkg::POS_W-1:0]    span_x_reg;
    logic [grb_pkg::SPAN_Y_W-1:0] span_y_reg;
    logic [grb_pkg::MASK_W-1:0]   mask_reg;
    logic [grb_pkg::COLOUR_W-1:0] pcol_reg;
    logic                         last_reg;

    assign y_now = grb_pkg::SPAN_Y_W'(py_reg) + grb_pkg::SPAN_Y_W'(s1_row_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_v_reg) begin
            span_x_reg <= px_reg;
            span_y_reg <= y_now;
            // rows below the screen's bottom edge plot nothing
            mask_reg   <= (y_now >= grb_pkg::SPAN_Y_W'(sheight_reg)) ?
                          '0 : (ram_rdata & xmask_reg);
            pcol_reg   <= colour_reg;
            last_reg   <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign span_x       = span_x_reg;
    assign span_y       = span_y_reg;
    assign pixel_mask   = mask_reg;
    assign pixel_colour = pcol_reg;
    assign last_row     = last_reg;

    assign status.rows_zero   = (rows_now == '0);
    assign status.s1_free     = !s1_v_reg || advance;
    assign status.s1_valid    = s1_v_reg;
    assign status.row_is_last = row_last;

endmodule

// ===== rtl/glyph_row_blitter_top.sv =====
// Bitmap glyph character generator. A load request (tuser 0) writes one row
// byte, bit 7 leftmost, into the glyph store at (code, load_row). A draw
// request (tuser 1) reads the glyph's rows from the store and emits one
// result per row: screen origin, an 8-bit pixel mask clipped to the glyph
// width and the screen bounds, the colour, and tlast on the final row.
// The store's single read port delivers one row per cycle while the result
// side does not stall. Each row passes the read stage and then the output
// register; the next request is taken only once the draw's last row has left
// the read stage, and result stalls hold it back. Codes wrap modulo
// GLYPH_COUNT. The store has no reset: draw only rows that were loaded. Write
// configuration only while the block is idle.
module glyph_row_blitter_top #(
    parameter int MAX_GLYPH_HEIGHT = grb_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int GLYPH_COUNT      = grb_pkg::DEF_GLYPH_COUNT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [grb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grb_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: code[7:0], load_row[12:8], row_bits[20:13], pos_x[36:21],
    //        pos_y[52:37], colour[84:53], zero pad[87:85]
    input  logic [87:0]                    s_tdata,
    // tuser: func[0]
    input  logic                           s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: span_x[15:0], span_y[32:16], pixel_mask[40:33],
    //        pixel_colour[72:41], zero pad[79:73]
    output logic [79:0]                    m_tdata,
    output logic                           m_tlast
);

    grb_pkg::grb_cmd_t    cmd;
    grb_pkg::grb_status_t status;

    logic [grb_pkg::POS_W-1:0]    span_x;
    logic [grb_pkg::SPAN_Y_W-1:0] span_y;
    logic [grb_pkg::MASK_W-1:0]   pixel_mask;
    logic [grb_pkg::COLOUR_W-1:0] pixel_colour;

    grb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grb_datapath #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .GLYPH_COUNT      (GLYPH_COUNT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .code         (s_tdata[7:0]),
        .load_row     (s_tdata[12:8]),
        .row_bits     (s_tdata[20:13]),
        .pos_x        (s_tdata[36:21]),
        .pos_y        (s_tdata[52:37]),
        .colour       (s_tdata[84:53]),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_tvalid),
        .m_tready     (m_tready),
        .span_x       (span_x),
        .span_y       (span_y),
        .pixel_mask   (pixel_mask),
        .pixel_colour (pixel_colour),
        .last_row     (m_tlast)
    );

    assign m_tdata = {7'b0, pixel_colour, pixel_mask, span_y, span_x};

endmodule

// ===== dv/glyph_row_blitter_top_tb.sv =====
`timescale 1ns / 100ps

module glyph_row_blitter_top_tb;

    localparam int MAX_GLYPH_HEIGHT = grb_pkg::DEF_MAX_GLYPH_HEIGHT;
    localparam int GLYPH_COUNT      = grb_pkg::DEF_GLYPH_COUNT;
    localparam int STORE_DEPTH      = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int ROW_CAP          = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;

    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 36;
    localparam int IDLE_SETTLE    = 8;
    localparam int END_DRAIN      = 40;
    localparam int HOLD_AFTER     = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 100;

    typedef enum logic [1:0] {ST_LOAD, ST_DRAW, ST_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [7:0]  code;
        logic [4:0]  lrow;
        logic [7:0]  bits;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] col;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
        logic        typed;
        logic [5:0]  t_rows;
        logic [5:0]  t_on;
        logic [7:0]  t_mask;
    } step_t;

    typedef struct packed {
        logic [15:0] span_x;
        logic [16:0] span_y;
        logic [7:0]  mask;
        logic [31:0] colour;
        logic        is_last;
    } row_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    // shadow of the block's registers and glyph store
    int reg_glyph_height  = int'(grb_pkg::RST_GLYPH_HEIGHT);
    int reg_glyph_width   = int'(grb_pkg::RST_GLYPH_WIDTH);
    int reg_screen_width  = int'(grb_pkg::RST_SCREEN_WIDTH);
    int reg_screen_height = int'(grb_pkg::RST_SCREEN_HEIGHT);
    logic [7:0] glyph_mem    [STORE_DEPTH];
    bit         glyph_loaded [STORE_DEPTH];

    row_result_t pending_rows [$];
    row_result_t seen_want;
    step_t       directed [$];
    int          known_codes [$];
    bit          is_known [GLYPH_COUNT];
    int          errors   = 0;
    int          rx_count = 0;
    bit          tx_calm  = 1'b0;

    glyph_row_blitter_top #(
        .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT),
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return $urandom_range(1, 3);
        end else if (roll < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // n leftmost pixels of a row byte
    function automatic logic [7:0] keep_left(input int n);
        logic [7:0] v;
        if (n > 8) n = 8;
        if (n <= 0) begin
            v = 8'h00;
        end else begin
            v = 8'hFF << (8 - n);
        end
        return v;
    endfunction

    // half the time near the clip edge, sometimes inside, sometimes anywhere
    function automatic logic [15:0] pick_coord(input int bound, input int reach);
        int v;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            v = bound + 1 - int'($urandom_range(0, reach));
            if (v < 0) v = 0;
        end else if (roll < 7) begin
            v = int'($urandom_range(0, (bound > 1) ? bound - 1 : 0));
        end else begin
            v = int'($urandom_range(0, 65535));
        end
        return v[15:0];
    endfunction

    function automatic bit glyph_ready(input int code, input int rows);
        int r;
        for (r = 0; r < rows; r++) begin
            if (!glyph_loaded[code * MAX_GLYPH_HEIGHT + r]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic step_t step_load(input logic [7:0] code, input logic [4:0] lrow,
                                        input logic [7:0] bits);
        step_t st;
        st = '0;
        st.kind = ST_LOAD;
        st.code = code;
        st.lrow = lrow;
        st.bits = bits;
        return st;
    endfunction

    function automatic step_t step_draw(input logic [7:0] code, input logic [15:0] px,
                                        input logic [15:0] py, input logic [31:0] col);
        step_t st;
        st = '0;
        st.kind = ST_DRAW;
        st.code = code;
        st.px = px;
        st.py = py;
        st.col = col;
        return st;
    endfunction

    function automatic step_t step_typed(input logic [7:0] code, input logic [15:0] px,
                                         input logic [15:0] py, input logic [31:0] col,
                                         input int rows, input int on, input logic [7:0] m);
        step_t st;
        st = step_draw(code, px, py, col);
        st.typed = 1'b1;
        st.t_rows = 6'(rows);
        st.t_on = 6'(on);
        st.t_mask = m;
        return st;
    endfunction

    function automatic step_t step_cfg(input logic [1:0] idx, input logic [15:0] val);
        step_t st;
        st = '0;
        st.kind = ST_CFG;
        st.cfg_idx = idx;
        st.cfg_val = val;
        return st;
    endfunction

    // update the store on a load, queue the clipped glyph rows on a draw
    task automatic render_rows(input step_t st);
        int code_i;
        int rows;
        int cols;
        int r;
        logic [7:0] xmask;
        row_result_t res;
        code_i = int'(st.code) % GLYPH_COUNT;
        if (st.kind == ST_LOAD) begin
            if (int'(st.lrow) < MAX_GLYPH_HEIGHT) begin
                glyph_mem[code_i * MAX_GLYPH_HEIGHT + int'(st.lrow)] = st.bits;
                glyph_loaded[code_i * MAX_GLYPH_HEIGHT + int'(st.lrow)] = 1'b1;
            end
        end else begin
            rows = (reg_glyph_height > ROW_CAP) ? ROW_CAP : reg_glyph_height;
            cols = (reg_glyph_width > 8) ? 8 : reg_glyph_width;
            xmask = keep_left(cols);
            if (int'(st.px) >= reg_screen_width) begin
                xmask = 8'h00;
            end else begin
                xmask &= keep_left(reg_screen_width - int'(st.px));
            end
            for (r = 0; r < rows; r++) begin
                res.span_x = st.px;
                res.span_y = 17'(int'(st.py) + r);
                res.mask = glyph_mem[code_i * MAX_GLYPH_HEIGHT + r] & xmask;
                if (int'(st.py) + r >= reg_screen_height) res.mask = 8'h00;
                res.colour = st.col;
                res.is_last = (r == rows - 1);
                pending_rows.push_back(res);
            end
        end
    endtask

    task automatic send_request(input step_t st);
        int gap;
        int r;
        row_result_t res;
        gap = tx_calm ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_gap());
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= (st.kind == ST_DRAW) ? grb_pkg::FUNC_DRAW : grb_pkg::FUNC_LOAD;
        s_tdata <= {3'b000, st.col, st.py, st.px, st.bits, st.lrow, st.code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (st.typed) begin
            for (r = 0; r < int'(st.t_rows); r++) begin
                res.span_x = st.px;
                res.span_y = 17'(int'(st.py) + r);
                res.mask = (r < int'(st.t_on)) ? st.t_mask : 8'h00;
                res.colour = st.col;
                res.is_last = (r == int'(st.t_rows) - 1);
                pending_rows.push_back(res);
            end
        end else begin
            render_rows(st);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            grb_pkg::CFG_GLYPH_HEIGHT:
                reg_glyph_height = int'(val[grb_pkg::GHEIGHT_W-1:0]);
            grb_pkg::CFG_GLYPH_WIDTH:
                reg_glyph_width = int'(val[grb_pkg::GWIDTH_W-1:0]);
            grb_pkg::CFG_SCREEN_WIDTH:  reg_screen_width = int'(val);
            grb_pkg::CFG_SCREEN_HEIGHT: reg_screen_height = int'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, wait for every pending row, then let a silent draw finish
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_count++;
            if (pending_rows.size() == 0) begin
                flag_mismatch("row with nothing pending", m_tdata[63:0], 64'd0);
            end else begin
                seen_want = pending_rows.pop_front();
                if (m_tdata[15:0] !== seen_want.span_x)
                    flag_mismatch("span_x", m_tdata[15:0], seen_want.span_x);
                if (m_tdata[32:16] !== seen_want.span_y)
                    flag_mismatch("span_y", m_tdata[32:16], seen_want.span_y);
                if (m_tdata[40:33] !== seen_want.mask)
                    flag_mismatch("pixel_mask", m_tdata[40:33], seen_want.mask);
                if (m_tdata[72:41] !== seen_want.colour)
                    flag_mismatch("pixel_colour", m_tdata[72:41], seen_want.colour);
                if (m_tlast !== seen_want.is_last)
                    flag_mismatch("tlast", m_tlast, seen_want.is_last);
            end
        end
    end

    initial begin : result_sink
        int stall_left;
        int calm_left;
        int hold_left;
        bit held;
        stall_left = 0;
        calm_left = 0;
        hold_left = 0;
        held = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            // one long hold-off so the block backs up into its request side
            if (!held && rx_count >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 199) == 0) begin
                    calm_left = $urandom_range(40, 160);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int issued;
        int eff_h;
        int r;
        int n;
        int code;
        bit broken;
        logic [15:0] h;
        logic [15:0] w;
        logic [15:0] sw;
        logic [15:0] sh;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = grb_pkg::CFG_GLYPH_HEIGHT;
        cfg_data = 16'h0000;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = grb_pkg::FUNC_LOAD;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // solid glyph at the top code, so masks show the clipping alone
        for (r = 0; r < 16; r++) begin
            directed.push_back(step_load(8'hFF, 5'(r), 8'hFF));
        end
        directed.push_back(step_load(8'h00, 5'd31, 8'h00));
        directed.push_back(step_typed(8'hFF, 16'd0, 16'd0, 32'h0000_0000, 16, 16, 8'hFF));
        directed.push_back(step_typed(8'hFF, 16'd636, 16'd0, 32'hFFFF_FFFF, 16, 16, 8'hF0));
        directed.push_back(step_typed(8'hFF, 16'd640, 16'd100, 32'h1234_5678, 16, 16, 8'h00));
        directed.push_back(step_typed(8'hFF, 16'd10, 16'd470, 32'hA5A5_5A5A, 16, 10, 8'hFF));
        directed.push_back(step_typed(8'hFF, 16'hFFFF, 16'hFFFF, 32'h8000_0001, 16, 16, 8'h00));
        directed.push_back(step_cfg(grb_pkg::CFG_GLYPH_WIDTH, 16'd3));
        directed.push_back(step_cfg(grb_pkg::CFG_GLYPH_HEIGHT, 16'd1));
        directed.push_back(step_typed(8'hFF, 16'd0, 16'd479, 32'h0F0F_F0F0, 1, 1, 8'hE0));

        foreach (directed[i]) begin
            if (directed[i].kind == ST_CFG) begin
                settle_idle();
                write_reg(directed[i].cfg_idx, directed[i].cfg_val);
            end else begin
                send_request(directed[i]);
            end
        end
        known_codes.push_back(255);
        is_known[255] = 1'b1;

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin h = 16'd4;  w = 16'd8;  sw = 16'd640;  sh = 16'd480;  end
                1: begin h = 16'd1;  w = 16'd1;  sw = 16'd1;    sh = 16'd1;    end
                2: begin h = 16'd63; w = 16'd15; sw = 16'hFFFF; sh = 16'hFFFF; end
                3: begin h = 16'd0;  w = 16'd5;  sw = 16'd200;  sh = 16'd100;  end
                4: begin h = 16'd8;  w = 16'd0;  sw = 16'd640;  sh = 16'd480;  end
                default: begin
                    // bits above the register width ride along and must be dropped
                    h = 16'($urandom_range(1, 12)) | 16'($urandom_range(0, 1023) << 6);
                    w = 16'($urandom_range(1, 15)) | 16'($urandom_range(0, 4095) << 4);
                    sw = $urandom_range(0, 1) ? 16'($urandom_range(1, 300))
                                              : 16'($urandom_range(1, 65535));
                    sh = $urandom_range(0, 1) ? 16'($urandom_range(1, 300))
                                              : 16'($urandom_range(1, 65535));
                end
            endcase
            settle_idle();
            write_reg(grb_pkg::CFG_GLYPH_HEIGHT, h);
            write_reg(grb_pkg::CFG_GLYPH_WIDTH, w);
            write_reg(grb_pkg::CFG_SCREEN_WIDTH, sw);
            write_reg(grb_pkg::CFG_SCREEN_HEIGHT, sh);
            tx_calm = ($urandom_range(0, 3) == 0);
            eff_h = (reg_glyph_height > ROW_CAP) ? ROW_CAP : reg_glyph_height;
            issued = 0;
            while (issued < PHASE_ITEMS) begin
                n = $urandom_range(0, 9);
                if (n < 7) begin
                    // load the missing rows and some others at random, then draw the glyph if it is whole
                    if (known_codes.size() > 0 && $urandom_range(0, 1) == 0) begin
                        code = known_codes[$urandom_range(0, known_codes.size() - 1)];
                    end else begin
                        code = $urandom_range(0, GLYPH_COUNT - 1);
                    end
                    broken = ($urandom_range(0, 7) == 0);
                    for (r = 0; r < eff_h; r++) begin
                        if (broken && r > eff_h / 2) break;
                        if (!glyph_loaded[code * MAX_GLYPH_HEIGHT + r] ||
                            $urandom_range(0, 5) == 0) begin
                            send_request(step_load(8'(code), 5'(r),
                                                   8'($urandom_range(0, 255))));
                            issued++;
                        end
                    end
                    if (!broken && glyph_ready(code, eff_h)) begin
                        if (!is_known[code]) begin
                            is_known[code] = 1'b1;
                            known_codes.push_back(code);
                        end
                        repeat ($urandom_range(1, 3)) begin
                            send_request(step_draw(8'(code),
                                                   pick_coord(reg_screen_width, 8),
                                                   pick_coord(reg_screen_height, eff_h + 1),
                                                   $urandom()));
                            issued++;
                        end
                    end
                end else if (n < 9) begin
                    send_request(step_load(8'($urandom_range(0, 255)),
                                           5'($urandom_range(0, 31)),
                                           8'($urandom_range(0, 255))));
                    issued++;
                end else begin
                    code = known_codes[$urandom_range(0, known_codes.size() - 1)];
                    if (glyph_ready(code, eff_h)) begin
                        send_request(step_draw(8'(code), 16'($urandom_range(0, 65535)),
                                               16'($urandom_range(0, 65535)), $urandom()));
                        issued++;
                    end
                end
            end
        end

        settle_idle();
        repeat (END_DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
